FILE: src/cbd_pkg.sv
`default_nettype none

package cbd_pkg;

    // Decoder phases, one-hot.
    typedef enum logic [6:0] {
        PH_LINE_START  = 7'b0000001,
        PH_LINE_DIGITS = 7'b0000010,
        PH_LINE_REST   = 7'b0000100,
        PH_PAYLOAD     = 7'b0001000,
        PH_AFTER_DATA  = 7'b0010000,
        PH_AFTER_CR    = 7'b0100000,
        PH_DONE        = 7'b1000000
    } phase_t;

    // Closing status codes.
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_CLEAN    = 3'd2;
    localparam logic [2:0] ST_BAD_LINE = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    // Size line fault codes.
    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_NO_DIGIT = 2'd1;
    localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

    // Line terminator characters.
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // One result transfer.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic [2:0]  end_status;
        logic [31:0] partial_count;
        logic        last;
    } result_t;

    // Hex digit decode: bit 4 flags a digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/chunked_body_decoder.sv
// Chunked body decoder. Body bytes enter on the input channel, one per transfer,
// and chunk payload bytes leave on the result channel as they arrive. A new byte
// is taken in every cycle: the size-line parser and the chunk counters are
// combinational, and each result goes into an output register backed by one skid
// entry, so in_stall rises only when both hold results that the consumer has not
// taken. Each byte reaches the result port via the output register or skid entry. The
// transfer with last set closes each body; its end_status says how the body
// ended, and for a chunk cut short by the end of the body (status 5) the
// partial_count gives how many of that chunk's bytes were already sent, so the
// consumer can trim them. Chunk sizes wider than SIZE_BITS stop the output.
`default_nettype none

module chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_value,
    input  wire logic        byte_present,
    input  wire logic        end_of_body,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic [2:0]       end_status,
    output logic [31:0]      partial_count,
    output logic             last
);
    import cbd_pkg::*;

    // Decoder state.
    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] chunk_reg, chunk_next;
    logic [SIZE_BITS-1:0] left_reg, left_next;
    logic                 cr_reg, cr_next;
    logic [1:0]           fault_reg, fault_next;

    // Result buffering.
    logic    out_vld_reg, out_vld_next;
    result_t out_data_reg, out_data_next;
    logic    skid_vld_reg, skid_vld_next;
    result_t skid_data_reg, skid_data_next;

    // Per-byte signals.
    logic                 accept;
    logic                 emit;
    logic                 do_line;
    logic [2:0]           status;
    logic [4:0]           hex;
    logic                 new_res;
    result_t              new_data;
    logic [SIZE_BITS-1:0] left_dec;
    logic [SIZE_BITS-1:0] diff;
    logic [63:0]          diff_ext;
    logic                 take;

    assign accept   = in_valid && !in_stall;
    assign hex      = hex_decode(byte_value);
    assign left_dec = left_reg - SIZE_BITS'(1);
    assign take     = out_vld_reg && !res_stall;

    // Byte decode: payload counting and size-line parsing.
    always_comb
    begin
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        left_next  = left_reg;
        cr_next    = cr_reg;
        fault_next = fault_reg;
        emit       = 1'b0;
        do_line    = 1'b0;
        status     = ST_NONE;

        // Count a payload byte, or move into the line state that this byte is parsed from.
        if (byte_present)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    emit      = 1'b1;
                    left_next = (left_reg != '0) ? left_dec : left_reg;
                    if (left_reg == '0 || left_dec == '0)
                    begin
                        phase_next = PH_AFTER_DATA;
                    end
                end
                PH_AFTER_DATA:
                begin
                    if (byte_value == CH_CR)
                    begin
                        phase_next = PH_AFTER_CR;
                    end
                    else
                    begin
                        phase_next = PH_LINE_START;
                        chunk_next = '0;
                        cr_next    = 1'b0;
                        fault_next = FAULT_NONE;
                        do_line    = 1'b1;
                    end
                end
                PH_AFTER_CR:
                begin
                    // A lone CR opens the next size line without a digit.
                    phase_next = (byte_value == CH_LF) ? PH_LINE_START : PH_LINE_REST;
                    chunk_next = '0;
                    cr_next    = (byte_value != CH_LF);
                    fault_next = (byte_value == CH_LF) ? FAULT_NONE : FAULT_NO_DIGIT;
                    do_line    = (byte_value != CH_LF);
                end
                PH_LINE_START, PH_LINE_DIGITS, PH_LINE_REST:
                begin
                    do_line = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // One size-line character.
        if (do_line)
        begin
            if (cr_next && byte_value == CH_LF)
            begin
                cr_next = 1'b0;
                if (fault_next == FAULT_NO_DIGIT)
                begin
                    phase_next = PH_DONE;
                    status     = ST_BAD_LINE;
                end
                else if (fault_next == FAULT_OVERFLOW)
                begin
                    phase_next = PH_DONE;
                    status     = ST_OVERFLOW;
                end
                else if (chunk_next == '0)
                begin
                    phase_next = PH_DONE;
                    status     = ST_ZERO;
                end
                else
                begin
                    left_next  = chunk_next;
                    phase_next = PH_PAYLOAD;
                end
            end
            else
            begin
                cr_next = (byte_value == CH_CR);
                if (phase_next == PH_LINE_START)
                begin
                    if (hex[4])
                    begin
                        chunk_next = SIZE_BITS'(hex[3:0]);
                        phase_next = PH_LINE_DIGITS;
                    end
                    else
                    begin
                        fault_next = FAULT_NO_DIGIT;
                        phase_next = PH_LINE_REST;
                    end
                end
                else if (phase_next == PH_LINE_DIGITS)
                begin
                    if (hex[4])
                    begin
                        if (fault_next == FAULT_NONE)
                        begin
                            // Shifting in a digit overflows when the top nibble is set.
                            if (chunk_next[SIZE_BITS-1 -: 4] != 4'd0)
                            begin
                                fault_next = FAULT_OVERFLOW;
                            end
                            else
                            begin
                                chunk_next = {chunk_next[SIZE_BITS-5:0], hex[3:0]};
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_LINE_REST;
                    end
                end
            end
        end
    end

    // Bytes of the current chunk already sent.
    assign diff     = chunk_next - left_next;
    assign diff_ext = 64'(diff);

    // Result of this byte, including the closing result at the end of a body.
    always_comb
    begin
        new_res  = 1'b0;
        new_data = '0;
        if (status != ST_NONE)
        begin
            new_res             = 1'b1;
            new_data.end_status = status;
            new_data.last       = 1'b1;
        end
        else if (end_of_body)
        begin
            new_res                = (phase_reg != PH_DONE);
            new_data.out_byte      = emit ? byte_value : 8'd0;
            new_data.out_valid     = emit;
            new_data.last          = 1'b1;
            if (phase_next == PH_PAYLOAD && left_next != '0)
            begin
                new_data.end_status    = ST_TRUNC;
                new_data.partial_count = diff_ext[31:0];
            end
            else
            begin
                new_data.end_status = ST_CLEAN;
            end
        end
        else if (emit)
        begin
            new_res            = 1'b1;
            new_data.out_byte  = byte_value;
            new_data.out_valid = 1'b1;
        end
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LINE_START;
            chunk_reg <= '0;
            left_reg  <= '0;
            cr_reg    <= 1'b0;
            fault_reg <= FAULT_NONE;
        end
        else if (accept)
        begin
            if (end_of_body)
            begin
                phase_reg <= PH_LINE_START;
                chunk_reg <= '0;
                left_reg  <= '0;
                cr_reg    <= 1'b0;
                fault_reg <= FAULT_NONE;
            end
            else
            begin
                phase_reg <= phase_next;
                chunk_reg <= chunk_next;
                left_reg  <= left_next;
                cr_reg    <= cr_next;
                fault_reg <= fault_next;
            end
        end
    end

    // Output register and skid entry: the skid entry drains first.
    always_comb
    begin
        out_vld_next   = out_vld_reg;
        out_data_next  = out_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_data_next = skid_data_reg;
        if (skid_vld_reg)
        begin
            if (take)
            begin
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (accept && new_res)
        begin
            if (!out_vld_reg || take)
            begin
                out_vld_next  = 1'b1;
                out_data_next = new_data;
            end
            else
            begin
                skid_vld_next  = 1'b1;
                skid_data_next = new_data;
            end
        end
        else if (take)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Ports.
    assign in_stall      = skid_vld_reg;
    assign res_valid     = out_vld_reg;
    assign out_byte      = out_data_reg.out_byte;
    assign out_valid     = out_data_reg.out_valid;
    assign end_status    = out_data_reg.end_status;
    assign partial_count = out_data_reg.partial_count;
    assign last          = out_data_reg.last;

endmodule

`default_nettype wire

FILE: src/cbd_checker.sv
`default_nettype none

module cbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic [7:0]  out_byte,
    input wire logic        out_valid,
    input wire logic [2:0]  end_status,
    input wire logic [31:0] partial_count,
    input wire logic        last
);
    import cbd_pkg::*;

    // A stalled result transfer holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_byte) && $stable(out_valid)
            && $stable(end_status) && $stable(partial_count) && $stable(last))
    else $error("stalled result changed");

    // Any closing status comes only on the last transfer of a body, and vice versa.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((end_status != ST_NONE) == last))
    else $error("status and last disagree");

    // A payload byte never rides with a stop status.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> end_status == ST_NONE || end_status == ST_CLEAN
            || end_status == ST_TRUNC)
    else $error("payload byte with stop status");

    // A partial count appears only with a truncated chunk.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && partial_count != 32'd0 |-> end_status == ST_TRUNC)
    else $error("partial count without truncation");

    // A transfer without a payload byte must close the body.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> last)
    else $error("empty result that does not close the body");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (.*);

`default_nettype wire

FILE: test/chunked_body_decoder_tb.sv
`timescale 1ns / 100ps

module chunked_body_decoder_tb;

    import cbd_pkg::*;

    localparam int SIZE_BITS = 32;
    localparam logic [63:0] LEN_MAX =
        (SIZE_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << SIZE_BITS) - 64'd1);
    localparam int CYCLE_LIMIT = 600000;
    localparam int STIM_TARGET = 1750;
    localparam int HOLD_CYCLES = 400;

    // One queued input transfer, or a marker that makes the sender drain.
    typedef struct packed {
        logic [7:0] value;
        logic       present;
        logic       eob;
        logic       drain;
    } body_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  byte_value = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_body = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [2:0]  end_status;
    logic [31:0] partial_count;
    logic        last;

    chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .byte_value(byte_value),
        .byte_present(byte_present),
        .end_of_body(end_of_body),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .out_byte(out_byte),
        .out_valid(out_valid),
        .end_status(end_status),
        .partial_count(partial_count),
        .last(last)
    );

    body_item_t  body_stream[$];
    logic [7:0]  body_text[$];
    result_t     decoded_fifo[$];

    int          stim_count = 0;
    int          bytes_taken = 0;
    int          results_seen = 0;
    int          payload_seen = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          status_count[0:7];
    logic        in_fire = 1'b0;

    // Decoder state as the predictor tracks it.
    phase_t      dec_phase = PH_LINE_START;
    logic [63:0] dec_len = 64'd0;
    logic [63:0] dec_left = 64'd0;
    logic        dec_cr = 1'b0;
    logic [1:0]  dec_fault = FAULT_NONE;

    // Sender and receiver pacing.
    int          tx_gap = 0;
    int          tx_quiet = 0;
    int          rx_gap = 0;
    int          rx_quiet = 0;
    int          rx_hold_left = 0;
    int          hold_count = 0;
    int          hold_at = 500;
    body_item_t  tx_item;
    result_t     seen;
    result_t     want;

    // Clock and a single reset at the start of the run.
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Hex digit value of a character, or -1 when it is not a digit.
    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    task automatic open_size_line();
        dec_phase = PH_LINE_START;
        dec_len = 64'd0;
        dec_cr = 1'b0;
        dec_fault = FAULT_NONE;
    endtask

    task automatic restart_body();
        open_size_line();
        dec_left = 64'd0;
    endtask

    // One character of a size line; returns the stop status, if any.
    function automatic logic [2:0] size_line_char(input logic [7:0] c);
        int d;
        d = hex_digit_value(c);
        if (dec_cr && c == CH_LF)
        begin
            dec_cr = 1'b0;
            if (dec_fault == FAULT_NO_DIGIT)
            begin
                dec_phase = PH_DONE;
                return ST_BAD_LINE;
            end
            if (dec_fault == FAULT_OVERFLOW)
            begin
                dec_phase = PH_DONE;
                return ST_OVERFLOW;
            end
            if (dec_len == 64'd0)
            begin
                dec_phase = PH_DONE;
                return ST_ZERO;
            end
            dec_left = dec_len;
            dec_phase = PH_PAYLOAD;
            return ST_NONE;
        end
        dec_cr = (c == CH_CR);
        if (dec_phase == PH_LINE_START)
        begin
            if (d >= 0)
            begin
                dec_len = 64'(d);
                if (dec_len > LEN_MAX)
                begin
                    dec_fault = FAULT_OVERFLOW;
                end
                dec_phase = PH_LINE_DIGITS;
            end
            else
            begin
                dec_fault = FAULT_NO_DIGIT;
                dec_phase = PH_LINE_REST;
            end
        end
        else if (dec_phase == PH_LINE_DIGITS)
        begin
            if (d >= 0)
            begin
                if (dec_fault == FAULT_NONE)
                begin
                    if (dec_len > (LEN_MAX - 64'(d)) / 64'd16)
                    begin
                        dec_fault = FAULT_OVERFLOW;
                    end
                    else
                    begin
                        dec_len = dec_len * 64'd16 + 64'(d);
                    end
                end
            end
            else
            begin
                dec_phase = PH_LINE_REST;
            end
        end
        return ST_NONE;
    endfunction

    // Work out the result, if any, that one accepted body byte causes.
    task automatic decode_body_byte(input logic [7:0] b, input logic present, input logic eob);
        logic       emit;
        logic [2:0] status;
        logic       was_done;
        result_t    r;
        emit = 1'b0;
        status = ST_NONE;
        was_done = (dec_phase == PH_DONE);
        r = '0;
        if (present)
        begin
            case (dec_phase)
                PH_PAYLOAD:
                begin
                    emit = 1'b1;
                    if (dec_left > 64'd0)
                    begin
                        dec_left = dec_left - 64'd1;
                    end
                    if (dec_left == 64'd0)
                    begin
                        dec_phase = PH_AFTER_DATA;
                    end
                end
                PH_AFTER_DATA:
                begin
                    if (b == CH_CR)
                    begin
                        dec_phase = PH_AFTER_CR;
                    end
                    else
                    begin
                        open_size_line();
                        status = size_line_char(b);
                    end
                end
                PH_AFTER_CR:
                begin
                    open_size_line();
                    if (b != CH_LF)
                    begin
                        // The lone CR opens the next size line.
                        void'(size_line_char(CH_CR));
                        status = size_line_char(b);
                    end
                end
                PH_LINE_START, PH_LINE_DIGITS, PH_LINE_REST:
                begin
                    status = size_line_char(b);
                end
                default:
                begin
                end
            endcase
        end

        if (status != ST_NONE)
        begin
            r.end_status = status;
            r.last = 1'b1;
            decoded_fifo.insert(decoded_fifo.size(), r);
            if (eob)
            begin
                restart_body();
            end
        end
        else if (eob)
        begin
            // After a stop the closing marker gives no result.
            if (!was_done)
            begin
                if (dec_phase == PH_PAYLOAD && dec_left > 64'd0)
                begin
                    r.end_status = ST_TRUNC;
                    r.partial_count = 32'(dec_len - dec_left);
                end
                else
                begin
                    r.end_status = ST_CLEAN;
                end
                r.out_byte = emit ? b : 8'h00;
                r.out_valid = emit;
                r.last = 1'b1;
                decoded_fifo.insert(decoded_fifo.size(), r);
            end
            restart_body();
        end
        else if (emit)
        begin
            r.out_byte = b;
            r.out_valid = 1'b1;
            decoded_fifo.insert(decoded_fifo.size(), r);
        end
    endtask

    // Stimulus helpers.
    task automatic put(input logic [7:0] b, input logic present, input logic eob);
        body_item_t it;
        it.value = b;
        it.present = present;
        it.eob = eob;
        it.drain = 1'b0;
        body_stream.insert(body_stream.size(), it);
        if (present || eob)
        begin
            stim_count++;
        end
    endtask

    task automatic put_text(input string s, input logic eob_on_last);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            put(s[i], 1'b1, eob_on_last && (i == s.len() - 1));
        end
    endtask

    task automatic put_drain();
        body_item_t it;
        it = '0;
        it.drain = 1'b1;
        body_stream.insert(body_stream.size(), it);
    endtask

    // Append one character to the body under construction.
    task automatic add_char(input logic [7:0] c);
        body_text.insert(body_text.size(), c);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10)
        begin
            return 8'(int'("0") + v);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            return 8'(int'("a") + v - 10);
        end
        return 8'(int'("A") + v - 10);
    endfunction

    task automatic add_hex(input logic [63:0] n);
        int nd;
        int i;
        nd = 1;
        while (nd < 16 && (n >> (4 * nd)) != 64'd0)
        begin
            nd++;
        end
        for (i = nd - 1; i >= 0; i--)
        begin
            add_char(hex_char(int'((n >> (4 * i)) & 64'hF)));
        end
    endtask

    // Optional chunk extension, which the decoder skips.
    task automatic add_ext();
        if ($urandom_range(0, 99) < 15)
        begin
            add_char(";");
            repeat ($urandom_range(1, 5))
            begin
                add_char(8'($urandom_range(8'h20, 8'h7E)));
            end
        end
    endtask

    task automatic add_crlf();
        add_char(CH_CR);
        add_char(CH_LF);
    endtask

    task automatic add_random(input int n);
        repeat (n)
        begin
            add_char(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic int pick_chunk_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            return $urandom_range(1, 8);
        end
        if (r < 95)
        begin
            return $urandom_range(9, 40);
        end
        return $urandom_range(41, 120);
    endfunction

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
        begin
            return hex_char($urandom_range(0, 15));
        end
        if (r == 3)
        begin
            return CH_CR;
        end
        if (r == 4)
        begin
            return CH_LF;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // One random body: mostly well-formed chunk sequences, some noise and faults.
    task automatic gen_body();
        int          kind;
        int          sz;
        int          k;
        int          i;
        int          cut;
        logic        eob_on_byte;
        logic [63:0] big;
        body_text.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            repeat ($urandom_range(0, 4))
            begin
                sz = pick_chunk_size();
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 2))
                    begin
                        add_char("0");
                    end
                end
                add_hex(64'(sz));
                add_ext();
                add_crlf();
                add_random(sz);
                // Usually CRLF after the payload, sometimes none or a lone CR.
                k = $urandom_range(0, 9);
                if (k < 8)
                begin
                    add_crlf();
                end
                else if (k == 8)
                begin
                    add_char(CH_CR);
                end
            end
            if ($urandom_range(0, 4) != 0)
            begin
                add_char("0");
                add_ext();
                add_crlf();
                add_random($urandom_range(0, 3));
            end
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(1, 16))
            begin
                add_char(noise_char());
            end
        end
        else if (kind < 92)
        begin
            // Size line too wide for the length register.
            add_char(hex_char($urandom_range(1, 15)));
            repeat ($urandom_range(8, 10))
            begin
                add_char(hex_char($urandom_range(0, 15)));
            end
            add_crlf();
            add_random($urandom_range(0, 3));
        end
        else
        begin
            // Huge but legal size, cut short by the end of the body.
            if ($urandom_range(0, 3) == 0)
            begin
                big = LEN_MAX;
            end
            else
            begin
                big = {32'd0, 4'($urandom_range(1, 15)), 28'($urandom)};
            end
            add_hex(big);
            add_crlf();
            add_random($urandom_range(1, 10));
        end

        if (body_text.size() > 0 && $urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(0, body_text.size() - 1);
            while (body_text.size() > cut)
            begin
                body_text.delete(body_text.size() - 1);
            end
        end

        eob_on_byte = (body_text.size() > 0) && ($urandom_range(0, 9) < 6);
        for (i = 0; i < body_text.size(); i++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            put(body_text[i], 1'b1, eob_on_byte && (i == body_text.size() - 1));
        end
        if (!eob_on_byte)
        begin
            put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Accept side of the input channel: predict every accepted transfer.
    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && !in_stall;
        if (in_fire)
        begin
            decode_body_byte(byte_value, byte_present, end_of_body);
            bytes_taken++;
        end
    end

    // Sender: offers the next queued transfer once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (in_fire || !in_valid))
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (body_stream.size() > 0 && body_stream[0].drain)
            begin
                // Pause until every pending result has come out.
                if (decoded_fifo.size() == 0)
                begin
                    body_stream.delete(0);
                end
                in_valid <= 1'b0;
            end
            else if (body_stream.size() > 0)
            begin
                tx_item = body_stream.pop_front();
                byte_value <= tx_item.value;
                byte_present <= tx_item.present;
                end_of_body <= tx_item.eob;
                in_valid <= 1'b1;
                if (tx_quiet > 0)
                begin
                    tx_quiet--;
                    tx_gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 149) == 0)
                    begin
                        tx_quiet = $urandom_range(20, 100);
                    end
                    tx_gap = ($urandom_range(0, 99) < 55) ? 0 : pick_len();
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, quiet stretches, and two long hold-offs.
    always @(negedge clk)
    begin
        if (hold_count < 2 && bytes_taken >= hold_at)
        begin
            rx_hold_left = HOLD_CYCLES;
            hold_count++;
            hold_at = 1300;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            res_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            res_stall <= 1'b1;
        end
        else
        begin
            if (rx_quiet > 0)
            begin
                rx_quiet--;
            end
            else if ($urandom_range(0, 149) == 0)
            begin
                rx_quiet = $urandom_range(20, 100);
            end
            if (rx_quiet == 0 && $urandom_range(0, 99) < 30)
            begin
                rx_gap = pick_len() - 1;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    // Result checker: each result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            seen.out_byte = out_byte;
            seen.out_valid = out_valid;
            seen.end_status = end_status;
            seen.partial_count = partial_count;
            seen.last = last;
            results_seen++;
            if (decoded_fifo.size() == 0)
            begin
                error_count++;
                if (error_count <= 20)
                begin
                    $display("%0t: expected no result, ", $time,
                        "got byte %h valid %b status %0d partial %0d last %b",
                        out_byte, out_valid, end_status, partial_count, last);
                end
            end
            else
            begin
                want = decoded_fifo.pop_front();
                if (seen.out_byte !== want.out_byte || seen.out_valid !== want.out_valid
                    || seen.end_status !== want.end_status
                    || seen.partial_count !== want.partial_count || seen.last !== want.last)
                begin
                    error_count++;
                    if (error_count <= 20)
                    begin
                        $display("%0t: mismatch: expected byte %h valid %b status %0d ",
                            $time, want.out_byte, want.out_valid, want.end_status,
                            "partial %0d last %b, ", want.partial_count, want.last,
                            "got byte %h valid %b status %0d partial %0d last %b",
                            out_byte, out_valid, end_status, partial_count, last);
                    end
                end
            end
            if (out_valid === 1'b1)
            begin
                payload_seen++;
            end
            if (last === 1'b1)
            begin
                status_count[end_status]++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        for (int s = 0; s < 8; s++)
        begin
            status_count[s] = 0;
        end

        // Bare marker that is ignored, then an empty body.
        put(8'hFF, 1'b0, 1'b0);
        put(8'h00, 1'b0, 1'b1);
        // Chunk cut short; its last payload byte rides with the closing status.
        put_text("3\015\n", 1'b0);
        put(8'h00, 1'b1, 1'b0);
        put(8'hFF, 1'b1, 1'b1);
        // Lone CR after payload spoils the next size line; later bytes are ignored.
        put_text("1\015\nA\015x\015\n", 1'b0);
        put(8'h55, 1'b0, 1'b0);
        put(8'h80, 1'b1, 1'b1);
        // Size one past the widest length, closed on its LF.
        put_text("100000000\015\n", 1'b1);
        // Zero chunk, then a bare closing marker.
        put_text("0\015\n", 1'b0);
        put(8'h00, 1'b0, 1'b1);
        put_drain();

        while (stim_count < STIM_TARGET)
        begin
            gen_body();
            if ((stim_count / 400) != ((stim_count - 1) / 400) || $urandom_range(0, 59) == 0)
            begin
                put_drain();
            end
        end

        @(posedge rst_n);
        while (body_stream.size() != 0 || in_valid || decoded_fifo.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Ran %0d input transfers; checked %0d results with %0d payload bytes.",
            bytes_taken, results_seen, payload_seen);
        $display("Body endings: zero chunk %0d, clean %0d, bad line %0d, ",
            status_count[ST_ZERO], status_count[ST_CLEAN], status_count[ST_BAD_LINE],
            "overflow %0d, truncated %0d.",
            status_count[ST_OVERFLOW], status_count[ST_TRUNC]);
        if (error_count == 0 && decoded_fifo.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: chunked_body_decoder.f
src/cbd_pkg.sv
src/chunked_body_decoder.sv
src/cbd_checker.sv
test/chunked_body_decoder_tb.sv
